FILE: src/tfps_pkg.sv
// ----------------------------------------------------------------------------
// tfps_pkg
// shared types and constants for the trigger fire pulse sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package tfps_pkg;

  // number of per-player sequencers and the width of a player number
  localparam int unsigned PLAYERS  = 3;
  localparam int unsigned PLAYER_W = 2;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned CFG_W    = 16;

  // configuration register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_FIRE     = 2'd1,
    REG_COOLDOWN = 2'd2
  } reg_idx_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0] FIRE_RESET     = 16'd150;
  localparam logic [CFG_W-1:0] COOLDOWN_RESET = 16'd100;

  // sequencer phases, code 7 is unused
  typedef enum logic [2:0] {
    PH_WAIT_PRESS      = 3'd0,
    PH_CONFIRM_PRESS   = 3'd1,
    PH_FIRE            = 3'd2,
    PH_HOLD_OPEN       = 3'd3,
    PH_COOLDOWN        = 3'd4,
    PH_WAIT_RELEASE    = 3'd5,
    PH_CONFIRM_RELEASE = 3'd6
  } phase_t;

  // actuator command
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] fire_ticks;
    logic [CFG_W-1:0] cooldown_ticks;
  } cfg_t;

  // outcome of one sequencer step
  typedef struct packed {
    phase_t phase;
    logic   mark_load;
    cmd_t   cmd;
    logic   sound;
  } step_t;

endpackage

`default_nettype wire

FILE: src/trigger_fire_pulse_sequencer_top.sv
// ----------------------------------------------------------------------------
// trigger_fire_pulse_sequencer_top
// per-player trigger-to-actuator sequencer stepped by a stream of poll words
// ----------------------------------------------------------------------------
// path: an accepted poll word fills the input register, and the result register
//   is loaded from it once that register is empty or its word is taken
// throughput: one poll word per cycle while m_tready does not stall the result;
//   phase and mark registers are written with the result, so the next word sees them
// reset: synchronous rst returns every sequencer to waiting for a press with
//   a zero mark, loads the default timings and empties both registers
`default_nettype none

module trigger_fire_pulse_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // poll words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [31:0] now_tick, [32] ready_level,
                                      // [33] trigger_level, [39:34] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] player
  // result words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [1:0] gun_command, [2] sound_request,
                                      // [5:3] phase_out, [7:6] zero
  output logic [1:0]       m_tuser,   // [1:0] player_out
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers
  tfps_pkg::cfg_t cfg;

  // per-player state, each entry a plain register
  tfps_pkg::phase_t                phase     [tfps_pkg::PLAYERS];
  logic [tfps_pkg::TICK_W-1:0]     mark_time [tfps_pkg::PLAYERS];

  // input register
  logic                            in_valid;
  logic [tfps_pkg::PLAYER_W-1:0]   in_player;
  logic [tfps_pkg::TICK_W-1:0]     in_now;
  logic                            in_ready;
  logic                            in_trigger;

  // result register
  logic                            out_valid;
  logic [tfps_pkg::PLAYER_W-1:0]   out_player;
  tfps_pkg::cmd_t                  out_cmd;
  logic                            out_sound;
  tfps_pkg::phase_t                out_phase;

  logic                            advance;
  logic                            in_range;
  tfps_pkg::phase_t                cur_phase;
  logic [tfps_pkg::TICK_W-1:0]     cur_mark;
  tfps_pkg::step_t                 step;
  logic                            cfg_write;

  // ---------------------------------------------------------------- apb port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= tfps_pkg::DEBOUNCE_RESET;
      cfg.fire_ticks     <= tfps_pkg::FIRE_RESET;
      cfg.cooldown_ticks <= tfps_pkg::COOLDOWN_RESET;
    end else if (cfg_write) begin
      unique case (tfps_pkg::reg_idx_t'(paddr[3:2]))
        tfps_pkg::REG_DEBOUNCE: cfg.debounce_ticks <= pwdata[tfps_pkg::CFG_W-1:0];
        tfps_pkg::REG_FIRE:     cfg.fire_ticks     <= pwdata[tfps_pkg::CFG_W-1:0];
        tfps_pkg::REG_COOLDOWN: cfg.cooldown_ticks <= pwdata[tfps_pkg::CFG_W-1:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (tfps_pkg::reg_idx_t'(paddr[3:2]))
      tfps_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg.debounce_ticks};
      tfps_pkg::REG_FIRE:     prdata = {16'd0, cfg.fire_ticks};
      tfps_pkg::REG_COOLDOWN: prdata = {16'd0, cfg.cooldown_ticks};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- stream control
  // the result register moves on when empty or when its word is taken
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now     <= s_tdata[31:0];
      in_ready   <= s_tdata[32];
      in_trigger <= s_tdata[33];
      in_player  <= s_tuser;
    end
  end

  // ------------------------------------------------------------ state lookup
  assign in_range = (in_player < tfps_pkg::PLAYER_W'(tfps_pkg::PLAYERS));

  always_comb begin
    cur_phase = tfps_pkg::PH_WAIT_PRESS;
    cur_mark  = '0;
    if (in_range) begin
      cur_phase = phase[in_player];
      cur_mark  = mark_time[in_player];
    end
  end

  tfps_step u_step (
    .phase_cur     (cur_phase),
    .mark_cur      (cur_mark),
    .now_tick      (in_now),
    .ready_level   (in_ready),
    .trigger_level (in_trigger),
    .cfg           (cfg),
    .step          (step)
  );

  // per-player state is written only for an addressed, existing player
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(tfps_pkg::PLAYERS); i++) begin
        phase[i]     <= tfps_pkg::PH_WAIT_PRESS;
        mark_time[i] <= '0;
      end
    end else if (advance && in_range) begin
      phase[in_player] <= step.phase;
      if (step.mark_load) begin
        mark_time[in_player] <= in_now;
      end
    end
  end

  // ---------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // a poll for a missing player gives no command and phase zero
  always_ff @(posedge clk) begin
    if (advance) begin
      out_player <= in_player;
      if (in_range) begin
        out_cmd   <= step.cmd;
        out_sound <= step.sound;
        out_phase <= step.phase;
      end else begin
        out_cmd   <= tfps_pkg::CMD_NONE;
        out_sound <= 1'b0;
        out_phase <= tfps_pkg::PH_WAIT_PRESS;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_phase, out_sound, out_cmd};
  assign m_tuser  = out_player;

endmodule

`default_nettype wire

FILE: src/tfps_step.sv
// ----------------------------------------------------------------------------
// tfps_step
// next-phase logic of one sequencer for one poll word
// ----------------------------------------------------------------------------
`default_nettype none

module tfps_step (
  input  wire tfps_pkg::phase_t              phase_cur,
  input  wire logic [tfps_pkg::TICK_W-1:0]   mark_cur,
  input  wire logic [tfps_pkg::TICK_W-1:0]   now_tick,
  input  wire logic                          ready_level,
  input  wire logic                          trigger_level,
  input  wire tfps_pkg::cfg_t                cfg,
  output tfps_pkg::step_t                    step
);

  logic [tfps_pkg::TICK_W-1:0] elapsed;
  logic [tfps_pkg::TICK_W-1:0] debounce_w;
  logic [tfps_pkg::TICK_W-1:0] fire_w;
  logic [tfps_pkg::TICK_W-1:0] cooldown_w;
  logic                        debounce_done;

  // elapsed time wraps modulo 2^32
  assign elapsed    = now_tick - mark_cur;
  assign debounce_w = {{(tfps_pkg::TICK_W-tfps_pkg::CFG_W){1'b0}}, cfg.debounce_ticks};
  assign fire_w     = {{(tfps_pkg::TICK_W-tfps_pkg::CFG_W){1'b0}}, cfg.fire_ticks};
  assign cooldown_w = {{(tfps_pkg::TICK_W-tfps_pkg::CFG_W){1'b0}}, cfg.cooldown_ticks};
  assign debounce_done = (elapsed >= debounce_w);

  always_comb begin
    step.phase     = phase_cur;
    step.mark_load = 1'b0;
    step.cmd       = tfps_pkg::CMD_NONE;
    step.sound     = 1'b0;
    unique case (phase_cur)
      tfps_pkg::PH_WAIT_PRESS: begin
        if (!ready_level && !trigger_level) begin
          step.phase     = tfps_pkg::PH_CONFIRM_PRESS;
          step.mark_load = 1'b1;
        end
      end
      tfps_pkg::PH_CONFIRM_PRESS: begin
        if (debounce_done) begin
          step.phase = (ready_level || trigger_level) ? tfps_pkg::PH_WAIT_PRESS
                                                       : tfps_pkg::PH_FIRE;
        end
      end
      tfps_pkg::PH_FIRE: begin
        step.cmd       = tfps_pkg::CMD_OPEN;
        step.sound     = 1'b1;
        step.phase     = tfps_pkg::PH_HOLD_OPEN;
        step.mark_load = 1'b1;
      end
      tfps_pkg::PH_HOLD_OPEN: begin
        if (elapsed > fire_w) begin
          step.cmd       = tfps_pkg::CMD_CLOSE;
          step.phase     = tfps_pkg::PH_COOLDOWN;
          step.mark_load = 1'b1;
        end
      end
      tfps_pkg::PH_COOLDOWN: begin
        if (elapsed > cooldown_w) begin
          step.phase     = tfps_pkg::PH_WAIT_RELEASE;
          step.mark_load = 1'b1;
        end
      end
      tfps_pkg::PH_WAIT_RELEASE: begin
        // release time taken when the release is first seen
        if (trigger_level) begin
          step.phase     = tfps_pkg::PH_CONFIRM_RELEASE;
          step.mark_load = 1'b1;
        end
      end
      tfps_pkg::PH_CONFIRM_RELEASE: begin
        if (debounce_done) begin
          step.phase = trigger_level ? tfps_pkg::PH_WAIT_PRESS
                                     : tfps_pkg::PH_WAIT_RELEASE;
        end
      end
      default: begin
        step.phase = tfps_pkg::PH_WAIT_PRESS;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sim/tb_trigger_fire_pulse_sequencer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trigger_fire_pulse_sequencer_top
// self-checking bench for the per-player trigger fire pulse sequencer
// ----------------------------------------------------------------------------
// poll words come from a queue filled in phases. Each phase after the first
// sets its own timings over the config port, and each its own idling on both stream sides. Every
// accepted poll word is stepped through a local model of the three
// sequencers. The result word it must give is then queued, and the monitor
// checks each result word field by field against the oldest entry.
// ----------------------------------------------------------------------------

module tb_trigger_fire_pulse_sequencer_top;
  import tfps_pkg::*;

  // one poll word as the bench sees it, plus a flag that makes the driver
  // hold it back until every outstanding result word has come
  typedef struct {
    logic [PLAYER_W-1:0] player;
    logic [TICK_W-1:0]   now_tick;
    logic                ready_level;
    logic                trigger_level;
    bit                  drain;
  } poll_t;

  // one result word: what the sequencer commands after a poll
  typedef struct {
    logic [PLAYER_W-1:0] player;
    cmd_t                cmd;
    logic                sound;
    phase_t              phase;
  } shot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [31:0] now_tick, [32] ready_level, [33] trigger_level
  logic [1:0]  s_tuser = '0;   // [1:0] player
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [1:0] gun_command, [2] sound_request, [5:3] phase_out
  logic [1:0]  m_tuser;        // [1:0] player_out
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  trigger_fire_pulse_sequencer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // model of the sequencers: timings, and per player a phase and a time mark
  logic [CFG_W-1:0]  cfg_debounce;
  logic [CFG_W-1:0]  cfg_fire;
  logic [CFG_W-1:0]  cfg_cooldown;
  phase_t            seq_phase [PLAYERS];
  logic [TICK_W-1:0] seq_mark  [PLAYERS];

  poll_t poll_queue[$];    // poll words still to be offered
  shot_t due_commands[$];  // result words owed by the block, oldest first
  poll_t cur_poll;         // word currently on the slave side

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // stimulus shaping: a free-running clock per player and the state of the
  // press / release episode that the trigger line is going through
  logic [TICK_W-1:0] tick_clk    [PLAYERS];
  int                press_left  [PLAYERS];
  int                release_left[PLAYERS];

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // safety net against a hung handshake
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d want %0d", what, got, want);
    error_count++;
  endtask

  // one poll step of the addressed sequencer, state updated in place
  function automatic shot_t step_sequencer(poll_t p);
    shot_t             r;
    phase_t            ph;
    logic [TICK_W-1:0] elapsed;
    r.player = p.player;
    r.cmd    = CMD_NONE;
    r.sound  = 1'b0;
    r.phase  = PH_WAIT_PRESS;
    // out-of-range player: nothing moves, result is all quiet
    if (p.player >= PLAYERS) return r;
    ph      = seq_phase[p.player];
    elapsed = p.now_tick - seq_mark[p.player];
    case (ph)
      PH_WAIT_PRESS: begin
        if (!p.ready_level && !p.trigger_level) begin
          ph = PH_CONFIRM_PRESS;
          seq_mark[p.player] = p.now_tick;
        end
      end
      PH_CONFIRM_PRESS: begin
        // press lost at confirmation goes back to waiting
        if (elapsed >= {16'h0, cfg_debounce})
          ph = (p.ready_level || p.trigger_level) ? PH_WAIT_PRESS : PH_FIRE;
      end
      PH_FIRE: begin
        r.cmd   = CMD_OPEN;
        r.sound = 1'b1;
        ph      = PH_HOLD_OPEN;
        seq_mark[p.player] = p.now_tick;
      end
      PH_HOLD_OPEN: begin
        if (elapsed > {16'h0, cfg_fire}) begin
          r.cmd = CMD_CLOSE;
          ph    = PH_COOLDOWN;
          seq_mark[p.player] = p.now_tick;
        end
      end
      PH_COOLDOWN: begin
        if (elapsed > {16'h0, cfg_cooldown}) begin
          ph = PH_WAIT_RELEASE;
          seq_mark[p.player] = p.now_tick;
        end
      end
      PH_WAIT_RELEASE: begin
        // the release time is taken from this very poll
        if (p.trigger_level) begin
          ph = PH_CONFIRM_RELEASE;
          seq_mark[p.player] = p.now_tick;
        end
      end
      PH_CONFIRM_RELEASE: begin
        // trigger pressed again at confirmation goes back to waiting for release
        if (elapsed >= {16'h0, cfg_debounce})
          ph = p.trigger_level ? PH_WAIT_PRESS : PH_WAIT_RELEASE;
      end
      default: ph = PH_WAIT_PRESS;
    endcase
    seq_phase[p.player] = ph;
    r.phase = ph;
    return r;
  endfunction

  // driver: offers the next poll word whenever the slave side is free
  always @(posedge clk) begin
    logic show;
    if (rst) begin
      s_tvalid     <= 1'b0;
      cfg_debounce <= DEBOUNCE_RESET;
      cfg_fire     <= FIRE_RESET;
      cfg_cooldown <= COOLDOWN_RESET;
      for (int i = 0; i < PLAYERS; i++) begin
        seq_phase[i] <= PH_WAIT_PRESS;
        seq_mark[i]  <= '0;
      end
    end else begin
      // word taken at this edge: work out the result it owes
      if (s_tvalid && s_tready)
        due_commands.push_back(step_sequencer(cur_poll));
      if (!s_tvalid || s_tready) begin
        show = 1'b0;
        if (poll_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          // a drain word waits until the block has handed everything back
          if (!poll_queue[0].drain || due_commands.size() == 0)
            show = 1'b1;
        end
        if (show) begin
          cur_poll = poll_queue.pop_front();
          s_tdata  <= {6'b0, cur_poll.trigger_level, cur_poll.ready_level,
                       cur_poll.now_tick};
          s_tuser  <= cur_poll.player;
        end
        s_tvalid <= show;
      end
    end
  end

  // monitor: checks every result word and stalls the master side at random
  always @(posedge clk) begin
    shot_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_commands.size() == 0) begin
          report_mismatch("result word with nothing due, player", int'(m_tuser), 0);
        end else begin
          want = due_commands.pop_front();
          if (m_tuser !== want.player)
            report_mismatch("player_out", int'(m_tuser), int'(want.player));
          if (m_tdata[1:0] !== want.cmd)
            report_mismatch("gun_command", int'(m_tdata[1:0]), int'(want.cmd));
          if (m_tdata[2] !== want.sound)
            report_mismatch("sound_request", int'(m_tdata[2]), int'(want.sound));
          if (m_tdata[5:3] !== want.phase)
            report_mismatch("phase_out", int'(m_tdata[5:3]), int'(want.phase));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // register write: setup cycle, then access cycle, written when pready is high
  task automatic write_timing(reg_idx_t idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DEBOUNCE: cfg_debounce = value;
      REG_FIRE:     cfg_fire     = value;
      default:      cfg_cooldown = value;
    endcase
  endtask

  task automatic set_timings(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] fire,
                             logic [CFG_W-1:0] cool);
    write_timing(REG_DEBOUNCE, deb);
    write_timing(REG_FIRE, fire);
    write_timing(REG_COOLDOWN, cool);
  endtask

  // wait until the block holds nothing in its two stages, plus a margin
  task automatic wait_quiet();
    @(negedge clk);
    while (poll_queue.size() != 0 || s_tvalid || due_commands.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_poll(logic [1:0] player, logic [31:0] now, logic rdy, logic trg);
    poll_t item;
    item.player        = player;
    item.now_tick      = now;
    item.ready_level   = rdy;
    item.trigger_level = trg;
    item.drain         = 1'b0;
    poll_queue.push_back(item);
  endtask

  // time step between polls of one player, often aimed at the thresholds
  function automatic logic [31:0] pick_step();
    logic [31:0] mark;
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2, 3:    return $urandom_range(0, 8);
      8:       return $urandom_range(0, 140000);
      9:       return $urandom;
      default: begin
        case ($urandom_range(0, 2))
          0:       mark = {16'h0, cfg_debounce};
          1:       mark = {16'h0, cfg_fire};
          default: mark = {16'h0, cfg_cooldown};
        endcase
        // just below, on, or just past the threshold
        return mark + $urandom_range(0, 2) - 1;
      end
    endcase
  endfunction

  // mostly well-formed press / release episodes, some noise words
  task automatic add_random(int count, int drain_at);
    poll_t item;
    int    p;
    for (int i = 0; i < PLAYERS; i++) begin
      tick_clk[i]     = $urandom;
      press_left[i]   = 0;
      release_left[i] = 0;
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        item.player        = PLAYER_W'($urandom_range(0, 3));
        item.now_tick      = $urandom;
        item.ready_level   = 1'($urandom_range(0, 1));
        item.trigger_level = 1'($urandom_range(0, 1));
      end else begin
        p = $urandom_range(0, PLAYERS - 1);
        tick_clk[p] += pick_step();
        if (press_left[p] == 0 && release_left[p] == 0) begin
          press_left[p]   = $urandom_range(3, 12);
          release_left[p] = $urandom_range(1, 6);
        end
        if (press_left[p] != 0) begin
          item.trigger_level = 1'b0;
          press_left[p]--;
        end else begin
          item.trigger_level = 1'b1;
          release_left[p]--;
        end
        item.player      = PLAYER_W'(p);
        item.now_tick    = tick_clk[p];
        item.ready_level = ($urandom_range(0, 9) == 0);
      end
      item.drain = (i == drain_at);
      poll_queue.push_back(item);
    end
  endtask

  // main sequence
  initial begin
    logic [31:0] t0;
    t0 = 32'hFFFF_FFF0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: reset timings, no idling, directed walk then random
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_poll(2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1);  // player out of range
    add_poll(2'd3, 32'h0, 1'b0, 1'b0);
    add_poll(2'd1, 32'h0, 1'b1, 1'b1);
    add_poll(2'd2, 32'hFFFF_FFFF, 1'b0, 1'b1);   // ready but not pressed
    add_poll(2'd2, 32'hFFFF_FFFF, 1'b1, 1'b0);   // pressed but not ready
    // player 0 goes round the whole cycle with the clock wrapping past zero
    add_poll(2'd0, t0,       1'b0, 1'b0);
    add_poll(2'd0, t0 + 19,  1'b0, 1'b0);        // one tick short of debounce
    add_poll(2'd0, t0 + 20,  1'b1, 1'b0);        // press lost while confirming
    add_poll(2'd0, t0 + 21,  1'b0, 1'b0);
    add_poll(2'd0, t0 + 41,  1'b0, 1'b0);
    add_poll(2'd0, t0 + 42,  1'b0, 1'b1);        // opens and asks for the sound
    add_poll(2'd0, t0 + 192, 1'b0, 1'b1);        // exactly fire ticks: still open
    add_poll(2'd0, t0 + 193, 1'b0, 1'b1);        // closes
    add_poll(2'd0, t0 + 293, 1'b0, 1'b0);
    add_poll(2'd0, t0 + 294, 1'b0, 1'b0);
    add_poll(2'd0, t0 + 300, 1'b0, 1'b0);        // still held
    add_poll(2'd0, t0 + 301, 1'b1, 1'b1);        // release seen, mark taken here
    add_poll(2'd0, t0 + 321, 1'b1, 1'b0);        // pressed again while confirming
    add_poll(2'd0, t0 + 322, 1'b1, 1'b1);
    add_poll(2'd0, t0 + 342, 1'b1, 1'b1);        // release confirmed
    add_poll(2'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_poll(2'd1, 32'h0, 1'b0, 1'b0);
    add_random(150, 60);
    wait_quiet();

    // phase 2: all timings zero, sender mostly idle
    set_timings(16'd0, 16'd0, 16'd0);
    send_idle_pct  = 86;
    recv_stall_pct = 0;
    add_random(150, -1);
    wait_quiet();

    // phase 3: all timings at their top, receiver mostly stalled
    set_timings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    add_random(150, -1);
    wait_quiet();

    // phase 4: short random timings, light idling on both sides
    set_timings(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 40)),
                CFG_W'($urandom_range(0, 40)));
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    add_random(200, 90);
    wait_quiet();

    // phase 5: timings anywhere in range, no idling
    set_timings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random(150, -1);
    wait_quiet();

    // phase 6: tiny timings, both sides mostly idle
    set_timings(16'd1, 16'd2, 16'd3);
    send_idle_pct  = 86;
    recv_stall_pct = 86;
    add_random(150, -1);
    wait_quiet();

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
